// ===== src/assert_macros.svh =====
// Assertion macros shared by the next-PC calculator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rnpc_pkg.sv =====
// Types and constants shared by the next-PC calculator modules.
package rnpc_pkg;

   localparam int ADDR_W  = 64;
   localparam int INSTR_W = 32;
   localparam int REG_W   = 5;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_XLEN = 1'b0;

   // Queue between decoder and sequencer.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Address mask for RV32 operation.
   localparam logic [ADDR_W-1:0] WRAP32 = {{(ADDR_W-32){1'b0}}, {32{1'b1}}};

   // Instruction quadrants.
   localparam logic [1:0] QUAD_C1 = 2'b01;
   localparam logic [1:0] QUAD_C2 = 2'b10;
   localparam logic [1:0] QUAD_32 = 2'b11;

   // Compressed funct3 codes.
   localparam logic [2:0] F3_CJAL  = 3'b001;
   localparam logic [2:0] F3_CJR   = 3'b100;
   localparam logic [2:0] F3_CJ    = 3'b101;
   localparam logic [2:0] F3_CBEQZ = 3'b110;
   localparam logic [2:0] F3_CBNEZ = 3'b111;

   // Major opcodes, bits 6:2.
   localparam logic [4:0] OPC_BRANCH = 5'b11000;
   localparam logic [4:0] OPC_JALR   = 5'b11001;
   localparam logic [4:0] OPC_JAL    = 5'b11011;

   typedef enum logic [1:0] {
      KIND_SEQ,
      KIND_JUMP,
      KIND_BRANCH
   } kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0] seq_address;
      logic [ADDR_W-1:0] target_address;
      kind_type          kind;
      logic [REG_W-1:0]  base_register;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== src/rnpc_front.sv =====
// Front end: accepts a request, decodes it and computes its candidate addresses.
module rnpc_front (
   input  logic                            start,
   input  logic                            busy,
   input  logic                            xlen_is_64,
   input  logic [rnpc_pkg::ADDR_W-1:0]     req_pc,
   input  logic [rnpc_pkg::INSTR_W-1:0]    req_instruction,
   input  logic [rnpc_pkg::ADDR_W-1:0]     req_base_value,
   output logic                            push,
   output rnpc_pkg::entry_type             push_entry
);

   logic [rnpc_pkg::ADDR_W-1:0]  wrap;
   logic [rnpc_pkg::ADDR_W-1:0]  pc_m;
   logic [rnpc_pkg::ADDR_W-1:0]  base_m;
   logic [rnpc_pkg::ADDR_W-1:0]  base_op;
   logic [rnpc_pkg::INSTR_W-1:0] w;
   logic [1:0]                   quad;
   logic [2:0]                   f3;
   logic [4:0]                   op;
   logic [rnpc_pkg::ADDR_W-1:0]  off_cj;
   logic [rnpc_pkg::ADDR_W-1:0]  off_cb;
   logic [rnpc_pkg::ADDR_W-1:0]  off_b;
   logic [rnpc_pkg::ADDR_W-1:0]  off_jalr;
   logic [rnpc_pkg::ADDR_W-1:0]  off_j;
   logic [rnpc_pkg::ADDR_W-1:0]  off;
   logic [rnpc_pkg::ADDR_W-1:0]  target_sum;
   logic [rnpc_pkg::ADDR_W-1:0]  seq_sum;
   logic [rnpc_pkg::REG_W-1:0]   reg_sel;
   logic                         use_base;
   logic                         clear_lsb;
   rnpc_pkg::kind_type           kind;

   // Accept whenever the queue has room.
   assign push = start && !busy;

   // Cut operands to the configured width.
   assign wrap   = xlen_is_64 ? '1 : rnpc_pkg::WRAP32;
   assign pc_m   = req_pc & wrap;
   assign base_m = req_base_value & wrap;
   assign w      = req_instruction;
   assign quad   = w[1:0];
   assign f3     = w[15:13];
   assign op     = w[6:2];

   // Sign-extended immediates of the control-transfer formats.
   assign off_cj   = {{53{w[12]}}, w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
   assign off_cb   = {{56{w[12]}}, w[6:5], w[2], w[11:10], w[4:3], 1'b0};
   assign off_b    = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
   assign off_jalr = {{52{w[31]}}, w[31:20]};
   assign off_j    = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};

   // Classify the instruction.
   always_comb begin
      kind      = rnpc_pkg::KIND_SEQ;
      use_base  = 1'b0;
      clear_lsb = 1'b0;
      off       = '0;
      reg_sel   = '0;
      case (quad)
         rnpc_pkg::QUAD_C1: begin
            if (f3 == rnpc_pkg::F3_CJ || (f3 == rnpc_pkg::F3_CJAL && !xlen_is_64)) begin
               kind = rnpc_pkg::KIND_JUMP;
               off  = off_cj;
            end else if (f3 == rnpc_pkg::F3_CBEQZ || f3 == rnpc_pkg::F3_CBNEZ) begin
               kind = rnpc_pkg::KIND_BRANCH;
               off  = off_cb;
            end
         end
         rnpc_pkg::QUAD_C2: begin
            if (f3 == rnpc_pkg::F3_CJR && w[6:2] == '0 && w[11:7] != '0) begin
               kind      = rnpc_pkg::KIND_JUMP;
               use_base  = 1'b1;
               clear_lsb = 1'b1;
               reg_sel   = w[11:7];
            end
         end
         rnpc_pkg::QUAD_32: begin
            case (op)
               rnpc_pkg::OPC_BRANCH: begin
                  kind = rnpc_pkg::KIND_BRANCH;
                  off  = off_b;
               end
               rnpc_pkg::OPC_JALR: begin
                  kind      = rnpc_pkg::KIND_JUMP;
                  use_base  = 1'b1;
                  clear_lsb = 1'b1;
                  reg_sel   = w[19:15];
                  off       = off_jalr;
               end
               rnpc_pkg::OPC_JAL: begin
                  kind = rnpc_pkg::KIND_JUMP;
                  off  = off_j;
               end
               default: begin
                  kind = rnpc_pkg::KIND_SEQ;
               end
            endcase
         end
         default: begin
            kind = rnpc_pkg::KIND_SEQ;
         end
      endcase
   end

   // Register x0 always reads as zero.
   assign base_op = (reg_sel == '0) ? '0 : base_m;

   // Target and fall-through adders.
   assign target_sum = (use_base ? base_op : pc_m) + off;
   assign seq_sum    = pc_m + ((quad == rnpc_pkg::QUAD_32) ? 64'd4 : 64'd2);

   always_comb begin
      push_entry.seq_address    = seq_sum & wrap;
      push_entry.target_address = target_sum & wrap & {{(rnpc_pkg::ADDR_W-1){1'b1}}, !clear_lsb};
      push_entry.kind           = kind;
      push_entry.base_register  = reg_sel;
   end

endmodule

// ===== src/rnpc_queue.sv =====
// Short queue of decoded requests between front end and sequencer.
`include "assert_macros.svh"

module rnpc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rnpc_pkg::entry_type         push_entry,
   input  logic                        pop,
   output rnpc_pkg::entry_type         head_entry,
   output rnpc_pkg::queue_status_type  status
);

   rnpc_pkg::entry_type              entries_ff [rnpc_pkg::QUEUE_DEPTH];
   logic [rnpc_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [rnpc_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [rnpc_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [rnpc_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [rnpc_pkg::QCNT_W-1:0]      count_ff;
   logic [rnpc_pkg::QCNT_W-1:0]      count_in;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == rnpc_pkg::QCNT_W'(rnpc_pkg::QUEUE_DEPTH));

   `ASSERT_ALWAYS(a_queue_no_overflow, clock, reset, !(push && status.full), "request pushed into a full queue")
   `ASSERT_ALWAYS(a_queue_no_underflow, clock, reset, !(pop && status.empty), "request popped from an empty queue")

endmodule

// ===== src/rnpc_back.sv =====
// Back end: turns each decoded request into one or two result strobes.
`include "assert_macros.svh"

module rnpc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rnpc_pkg::entry_type                 head_entry,
   input  rnpc_pkg::queue_status_type          status,
   output logic                                pop,
   output logic                                rsp_strobe,
   output logic [rnpc_pkg::ADDR_W-1:0]         rsp_next_address,
   output logic                                rsp_is_taken_target,
   output logic [rnpc_pkg::REG_W-1:0]          rsp_base_register,
   output logic                                rsp_last_of_run
);

   logic                          phase_ff;
   logic                          phase_in;
   logic                          emit;
   logic                          first_of_two;
   logic                          strobe_ff;
   logic [rnpc_pkg::ADDR_W-1:0]   address_ff;
   logic [rnpc_pkg::ADDR_W-1:0]   address_in;
   logic                          taken_ff;
   logic                          taken_in;
   logic [rnpc_pkg::REG_W-1:0]    reg_ff;
   logic                          last_ff;

   // A branch gives two results: the fall-through address first, then the target.
   assign emit         = !status.empty;
   assign first_of_two = (head_entry.kind == rnpc_pkg::KIND_BRANCH) && !phase_ff;
   assign pop          = emit && !first_of_two;

   always_comb begin
      phase_in = phase_ff;
      if (emit) begin
         phase_in = first_of_two;
      end
   end

   // Select the address for this cycle.
   always_comb begin
      if (first_of_two || head_entry.kind == rnpc_pkg::KIND_SEQ) begin
         address_in = head_entry.seq_address;
         taken_in   = 1'b0;
      end else begin
         address_in = head_entry.target_address;
         taken_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         strobe_ff <= emit;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (emit) begin
         address_ff <= address_in;
         taken_ff   <= taken_in;
         reg_ff     <= head_entry.base_register;
         last_ff    <= !first_of_two;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_next_address    = address_ff;
   assign rsp_is_taken_target = taken_ff;
   assign rsp_base_register   = reg_ff;
   assign rsp_last_of_run     = last_ff;

   `ASSERT_NEXT(a_back_run_completes, clock, reset, rsp_strobe && !rsp_last_of_run, rsp_strobe && rsp_last_of_run, "branch run not completed in the next cycle")
   `ASSERT_ALWAYS(a_back_first_is_fallthrough, clock, reset, !(rsp_strobe && !rsp_last_of_run && rsp_is_taken_target), "first result of a branch marked as taken")

endmodule

// ===== src/riscv_next_pc_calculator_core.sv =====
// Next-PC calculator: top level with configuration register, decoder, queue and sequencer.
// With the queue empty, an accepted request is written into the queue at the accepting edge,
// then into the result registers, which drive the first result strobe.
// Throughput: one request per cycle for jumps and sequential code while not busy; branches
// are slower, set by the single result port that sends two addresses per branch.
// busy rises only when the two-entry queue is full; results cannot be held off.
// Reset is synchronous: it empties the queue and selects RV64; no clearing pass.
module riscv_next_pc_calculator_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [rnpc_pkg::ADDR_W-1:0]         req_pc,
   input  logic [rnpc_pkg::INSTR_W-1:0]        req_instruction,
   input  logic [rnpc_pkg::ADDR_W-1:0]         req_base_value,
   // Result channel
   output logic                                rsp_strobe,
   output logic [rnpc_pkg::ADDR_W-1:0]         rsp_next_address,
   output logic                                rsp_is_taken_target,
   output logic [rnpc_pkg::REG_W-1:0]          rsp_base_register,
   output logic                                rsp_last_of_run,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rnpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rnpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rnpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic                        xlen_is_64_ff;
   logic                        xlen_is_64_in;
   logic                        csr_write;
   logic                        push;
   logic                        pop;
   rnpc_pkg::entry_type         push_entry;
   rnpc_pkg::entry_type         head_entry;
   rnpc_pkg::queue_status_type  status;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      xlen_is_64_in = xlen_is_64_ff;
      if (csr_write && paddr[2] == rnpc_pkg::CSR_IDX_XLEN) begin
         xlen_is_64_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xlen_is_64_ff <= 1'b1;
      end else begin
         xlen_is_64_ff <= xlen_is_64_in;
      end
   end

   assign prdata = (paddr[2] == rnpc_pkg::CSR_IDX_XLEN) ?
                   {{(rnpc_pkg::CSR_DATA_W-1){1'b0}}, xlen_is_64_ff} : '0;

   // The queue being full holds off new requests.
   assign busy = status.full;

   rnpc_front u_front (
      .start           (start),
      .busy            (busy),
      .xlen_is_64      (xlen_is_64_ff),
      .req_pc          (req_pc),
      .req_instruction (req_instruction),
      .req_base_value  (req_base_value),
      .push            (push),
      .push_entry      (push_entry)
   );

   rnpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   rnpc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_entry          (head_entry),
      .status              (status),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_next_address    (rsp_next_address),
      .rsp_is_taken_target (rsp_is_taken_target),
      .rsp_base_register   (rsp_base_register),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule
